[rtl/core/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// Shared constants, types and helpers of the text terminal character engine.
// ----------------------------------------------------------------------------
package tte_pkg;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int MAX_PARAMS    = 10;
   localparam int SCREEN_CELLS  = ROWS * COLUMNS;
   localparam int LAST_ROW_POS  = (ROWS - 1) * COLUMNS;

   localparam logic [31:0] COLOUR_MAP_RESET = 32'h7351_6240;
   localparam logic [3:0]  FG_RESET         = 4'd7;
   localparam logic [3:0]  BG_RESET         = 4'd0;

   localparam logic [7:0] CHAR_BS       = 8'h08;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_LF       = 8'h0a;
   localparam logic [7:0] CHAR_CR       = 8'h0d;
   localparam logic [7:0] CHAR_ESC      = 8'h1b;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
   localparam logic [7:0] CHAR_SEMI     = 8'h3b;
   localparam logic [7:0] CHAR_SGR_END  = 8'h6d;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;

   localparam logic [7:0] SGR_FG_FIRST  = 8'd30;
   localparam logic [7:0] SGR_FG_LAST   = 8'd37;
   localparam logic [7:0] SGR_BG_FIRST  = 8'd40;
   localparam logic [7:0] SGR_BG_LAST   = 8'd47;

   typedef struct packed {
      logic       active;
      logic [7:0] attr_cur;
      logic [7:0] attr_next;
   } tte_esc_status_type;

   typedef struct packed {
      logic        cell_write;
      logic [10:0] cell_index;
      logic [15:0] cell_value;
      logic        scroll_up;
      logic [10:0] cursor_position;
   } tte_cell_type;

   typedef struct packed {
      logic        cell_write;
      logic [10:0] cell_index;
      logic [15:0] cell_value;
      logic        scroll_up;
      logic [10:0] cursor_position;
      logic [7:0]  attribute_now;
   } tte_result_type;

   function automatic logic [10:0] lin_pos(input logic [4:0] row, input logic [6:0] col);
      lin_pos = 11'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

[rtl/core/tte_ifs.sv]
// ----------------------------------------------------------------------------
// tte_ifs
// Valid/ready channels of the text terminal character engine.
// ----------------------------------------------------------------------------
interface tte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface tte_rsp_if;
   logic        valid;
   logic        ready;
   logic        cell_write;
   logic [10:0] cell_index;
   logic [15:0] cell_value;
   logic        scroll_up;
   logic [10:0] cursor_position;
   logic [7:0]  attribute_now;

   modport source (output valid, output cell_write, output cell_index, output cell_value,
                   output scroll_up, output cursor_position, output attribute_now,
                   input ready);
   modport sink   (input valid, input cell_write, input cell_index, input cell_value,
                   input scroll_up, input cursor_position, input attribute_now,
                   output ready);
endinterface

interface tte_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] colour_map;

   modport source (output valid, output colour_map, input ready);
   modport sink   (input valid, input colour_map, output ready);
endinterface

[rtl/core/tte_escape.sv]
// ----------------------------------------------------------------------------
// tte_escape
// ANSI escape parser and SGR colour state.
// ----------------------------------------------------------------------------
module tte_escape (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  char_code,
   input  logic [31:0]                 colour_map,
   output tte_pkg::tte_esc_status_type status
);

   logic       in_escape_ff, in_escape_in;
   logic       csi_seen_ff, csi_seen_in;
   logic [3:0] param_count_ff, param_count_in;
   // only the first two parameters are ever applied
   logic [7:0] param0_ff, param0_in;
   logic [7:0] param1_ff, param1_in;
   logic [3:0] fg_ff, fg_in;
   logic [3:0] bg_ff, bg_in;
   logic [7:0] digit;
   logic [2:0] fg_sel, bg_sel;

   assign digit  = char_code - tte_pkg::CHAR_ZERO;
   assign fg_sel = 3'(param0_ff - tte_pkg::SGR_FG_FIRST);
   assign bg_sel = 3'(param1_ff - tte_pkg::SGR_BG_FIRST);

   always_comb begin
      in_escape_in   = in_escape_ff;
      csi_seen_in    = csi_seen_ff;
      param_count_in = param_count_ff;
      param0_in      = param0_ff;
      param1_in      = param1_ff;
      fg_in          = fg_ff;
      bg_in          = bg_ff;
      if (!in_escape_ff) begin
         if (char_code == tte_pkg::CHAR_ESC) begin
            in_escape_in = 1'b1;
            csi_seen_in  = 1'b0;
         end
      end else if (char_code == tte_pkg::CHAR_SGR_END) begin
         in_escape_in = 1'b0;
         if (csi_seen_ff && (param_count_ff == 4'd1 || param_count_ff == 4'd2)) begin
            if (param0_ff >= tte_pkg::SGR_FG_FIRST && param0_ff <= tte_pkg::SGR_FG_LAST) begin
               fg_in = colour_map[{fg_sel, 2'b00} +: 4];
            end
            if (param_count_ff == 4'd2 && param1_ff >= tte_pkg::SGR_BG_FIRST &&
                param1_ff <= tte_pkg::SGR_BG_LAST) begin
               bg_in = colour_map[{bg_sel, 2'b00} +: 4];
            end
         end
      end else if (char_code == tte_pkg::CHAR_LBRACKET) begin
         csi_seen_in    = 1'b1;
         param_count_in = 4'd1;
         param0_in      = '0;
         param1_in      = '0;
      end else if (!csi_seen_ff) begin
         in_escape_in = in_escape_ff;
      end else if (char_code == tte_pkg::CHAR_SEMI) begin
         if (param_count_ff < 4'(tte_pkg::MAX_PARAMS)) begin
            param_count_in = param_count_ff + 4'd1;
         end
      end else if (char_code >= tte_pkg::CHAR_ZERO && char_code <= tte_pkg::CHAR_NINE) begin
         if (param_count_ff == 4'd1) begin
            param0_in = (param0_ff * 8'd10) + digit;
         end else if (param_count_ff == 4'd2) begin
            param1_in = (param1_ff * 8'd10) + digit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_escape_ff   <= 1'b0;
         csi_seen_ff    <= 1'b0;
         param_count_ff <= '0;
         param0_ff      <= '0;
         param1_ff      <= '0;
         fg_ff          <= tte_pkg::FG_RESET;
         bg_ff          <= tte_pkg::BG_RESET;
      end else if (step) begin
         in_escape_ff   <= in_escape_in;
         csi_seen_ff    <= csi_seen_in;
         param_count_ff <= param_count_in;
         param0_ff      <= param0_in;
         param1_ff      <= param1_in;
         fg_ff          <= fg_in;
         bg_ff          <= bg_in;
      end
   end

   assign status.active    = in_escape_ff;
   assign status.attr_cur  = {bg_ff, fg_ff};
   assign status.attr_next = {bg_in, fg_in};

endmodule

[rtl/core/tte_cursor.sv]
// ----------------------------------------------------------------------------
// tte_cursor
// Cursor movement, cell write generation and scroll detection.
// ----------------------------------------------------------------------------
module tte_cursor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  char_code,
   input  tte_pkg::tte_esc_status_type esc,
   output tte_pkg::tte_cell_type       cursor_out
);

   logic [4:0] row_ff, row_in;
   logic [6:0] col_ff, col_in;
   logic [6:0] col_wr;
   logic [7:0] col_nx;
   logic [5:0] row_nx;
   logic       wr;
   logic [7:0] wr_char;
   logic       scroll;

   always_comb begin
      col_wr  = col_ff;
      col_nx  = {1'b0, col_ff};
      row_nx  = {1'b0, row_ff};
      wr      = 1'b0;
      wr_char = char_code;
      scroll  = 1'b0;
      if (!esc.active) begin
         unique case (char_code)
            tte_pkg::CHAR_BS: begin
               if (col_ff != 7'd0) begin
                  col_wr = col_ff - 7'd1;
               end
               col_nx  = {1'b0, col_wr};
               wr      = 1'b1;
               wr_char = tte_pkg::CHAR_SPACE;
            end
            tte_pkg::CHAR_TAB: begin
               col_nx = {1'b0, col_ff[6:3], 3'b000} + 8'd8;
            end
            tte_pkg::CHAR_LF: begin
               row_nx = row_nx + 6'd1;
               col_nx = '0;
            end
            tte_pkg::CHAR_CR: begin
               col_nx = '0;
            end
            tte_pkg::CHAR_ESC: begin
               col_nx = {1'b0, col_ff};
            end
            default: begin
               wr     = 1'b1;
               col_nx = {1'b0, col_ff} + 8'd1;
            end
         endcase
         if (col_nx >= 8'(tte_pkg::COLUMNS)) begin
            row_nx = row_nx + 6'd1;
            col_nx = '0;
         end
         if (row_nx >= 6'(tte_pkg::ROWS)) begin
            scroll = 1'b1;
            row_nx = 6'(tte_pkg::ROWS - 1);
            col_nx = '0;
         end
      end
      row_in = row_nx[4:0];
      col_in = col_nx[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (step) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign cursor_out.cell_write      = wr;
   assign cursor_out.cell_index      = wr ? tte_pkg::lin_pos(row_ff, col_wr) : '0;
   assign cursor_out.cell_value      = wr ? {esc.attr_cur, wr_char} : '0;
   assign cursor_out.scroll_up       = scroll;
   assign cursor_out.cursor_position = tte_pkg::lin_pos(row_in, col_in);

endmodule

[rtl/core/text_terminal_char_engine_core.sv]
// ----------------------------------------------------------------------------
// text_terminal_char_engine_core
// Text mode terminal engine: cursor control, cell writes and ANSI SGR colours.
// ----------------------------------------------------------------------------
// One word in, one word out. Throughput is one byte per clock while the rsp
// side is ready; a byte passes the input register, then the result register.
// Cursor, colour and escape parser state update as the byte moves between
// them, so the next byte sees the new state. The colour map register is
// written through the csr channel, which is always ready.
module text_terminal_char_engine_core (
   input  logic    clock,
   input  logic    reset,
   tte_req_if.sink   req_bus,
   tte_rsp_if.source rsp_bus,
   tte_csr_if.sink   csr_bus
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  char_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   tte_pkg::tte_result_type     rsp_data_ff, rsp_data_in;
   logic [31:0]                 colour_map_ff;
   logic                        advance;
   logic                        req_take;
   tte_pkg::tte_esc_status_type esc_status;
   tte_pkg::tte_cell_type       cursor_out;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_bus.ready);
   assign csr_bus.ready = 1'b1;

   tte_escape u_escape (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_code  (char_ff),
      .colour_map (colour_map_ff),
      .status     (esc_status)
   );

   tte_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_code  (char_ff),
      .esc        (esc_status),
      .cursor_out (cursor_out)
   );

   always_comb begin
      rsp_data_in.cell_write      = cursor_out.cell_write;
      rsp_data_in.cell_index      = cursor_out.cell_index;
      rsp_data_in.cell_value      = cursor_out.cell_value;
      rsp_data_in.scroll_up       = cursor_out.scroll_up;
      rsp_data_in.cursor_position = cursor_out.cursor_position;
      rsp_data_in.attribute_now   = esc_status.attr_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         colour_map_ff <= tte_pkg::COLOUR_MAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            colour_map_ff <= csr_bus.colour_map;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_bus.char_code;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.cell_write      = rsp_data_ff.cell_write;
   assign rsp_bus.cell_index      = rsp_data_ff.cell_index;
   assign rsp_bus.cell_value      = rsp_data_ff.cell_value;
   assign rsp_bus.scroll_up       = rsp_data_ff.scroll_up;
   assign rsp_bus.cursor_position = rsp_data_ff.cursor_position;
   assign rsp_bus.attribute_now   = rsp_data_ff.attribute_now;

   a_idle_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.cell_write |->
         rsp_data_ff.cell_index == '0 && rsp_data_ff.cell_value == '0)
      else $error("cell fields set without a cell write");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.scroll_up |->
         rsp_data_ff.cursor_position == 11'(tte_pkg::LAST_ROW_POS))
      else $error("scroll without cursor at start of last row");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.cursor_position < 11'(tte_pkg::SCREEN_CELLS))
      else $error("cursor position off screen");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(char_ff))
      else $error("stalled input word lost");

endmodule

[test/text_terminal_char_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// text_terminal_char_engine_core_tb
// Self-checking bench for the text terminal engine. Bytes go in on the req
// channel, and a local model of cursor, colour and escape state predicts every
// rsp word. Directed edge tests run first, then a receiver hold-off, then
// shaped random traffic under four idle mixes and several colour maps.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tte_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tte_req_if req_bus ();
   tte_rsp_if rsp_bus ();
   tte_csr_if csr_bus ();

   text_terminal_char_engine_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // terminal model state
   logic [31:0] map_model;
   logic [4:0]  cur_row;
   logic [6:0]  cur_col;
   logic [3:0]  fg_now;
   logic [3:0]  bg_now;
   logic        esc_active;
   logic        csi_active;
   logic [3:0]  param_count;
   logic [7:0]  sgr_params [MAX_PARAMS];

   tte_result_type expected_cells [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   logic rsp_hold     = 1'b0;

   int chars_sent     = 0;
   int cells_checked  = 0;
   int scrolls_seen   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   function automatic logic [4:0] sgr_colour(input logic [7:0] code, input logic [7:0] first);
      if (code >= first && code < first + 8)
         return {1'b1, 4'((map_model >> (4 * (code - first))) & 32'hf)};
      return 5'd0;
   endfunction

   function automatic tte_result_type predict_cell(input logic [7:0] b);
      tte_result_type res;
      int row;
      int col;
      int k;
      logic [4:0] hit;
      res = '0;
      row = cur_row;
      col = cur_col;
      if (esc_active) begin
         if (b == CHAR_SGR_END) begin
            esc_active = 1'b0;
            if (csi_active && (param_count == 1 || param_count == 2)) begin
               hit = sgr_colour(sgr_params[0], SGR_FG_FIRST);
               if (hit[4]) fg_now = hit[3:0];
               if (param_count == 2) begin
                  hit = sgr_colour(sgr_params[1], SGR_BG_FIRST);
                  if (hit[4]) bg_now = hit[3:0];
               end
            end
         end else if (b == CHAR_LBRACKET) begin
            csi_active = 1'b1;
            param_count = 4'd1;
            foreach (sgr_params[i]) sgr_params[i] = 8'd0;
         end else if (!csi_active) begin
         end else if (b == CHAR_SEMI) begin
            if (param_count < MAX_PARAMS) param_count++;
         end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            k = int'(param_count) - 1;
            if (k >= 0 && k < MAX_PARAMS)
               sgr_params[k] = 8'(int'(sgr_params[k]) * 10 + int'(b - CHAR_ZERO));
         end
      end else begin
         case (b)
            CHAR_BS: begin
               if (col > 0) col--;
               res.cell_write = 1'b1;
               res.cell_index = 11'(row * COLUMNS + col);
               res.cell_value = {bg_now, fg_now, CHAR_SPACE};
            end
            CHAR_TAB: col = ((col + 8) / 8) * 8;
            CHAR_LF: begin
               row++;
               col = 0;
            end
            CHAR_CR: col = 0;
            CHAR_ESC: begin
               esc_active = 1'b1;
               csi_active = 1'b0;
            end
            default: begin
               res.cell_write = 1'b1;
               res.cell_index = 11'(row * COLUMNS + col);
               res.cell_value = {bg_now, fg_now, b};
               col++;
            end
         endcase
         if (col >= COLUMNS) begin
            row++;
            col = 0;
         end
         if (row >= ROWS) begin
            res.scroll_up = 1'b1;
            row = ROWS - 1;
            col = 0;
         end
         cur_row = 5'(row);
         cur_col = 7'(col);
      end
      res.cursor_position = 11'(int'(cur_row) * COLUMNS + int'(cur_col));
      res.attribute_now = {bg_now, fg_now};
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // drivers; every task but hold_receiver starts and ends on a falling edge
   // ------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= c;
      do @(posedge clock); while (!req_bus.ready);
      expected_cells.push_back(predict_cell(c));
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_decimal(input int v);
      if (v >= 100) send_char(8'(CHAR_ZERO + v / 100));
      if (v >= 10) send_char(8'(CHAR_ZERO + (v / 10) % 10));
      send_char(8'(CHAR_ZERO + v % 10));
   endtask

   task automatic end_burst();
      req_bus.valid <= 1'b0;
      while (expected_cells.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_colour_map(input logic [31:0] v);
      csr_bus.valid      <= 1'b1;
      csr_bus.colour_map <= v;
      do @(posedge clock); while (!csr_bus.ready);
      map_model = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic hold_receiver(input int cycles);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold = 1'b0;
   endtask

   task automatic send_sgr();
      int fg_code;
      int bg_code;
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      if ($urandom_range(9) != 0) begin
         fg_code = ($urandom_range(4) != 0) ? int'($urandom_range(30, 37))
                                            : int'($urandom_range(0, 299));
         send_decimal(fg_code);
      end
      if ($urandom_range(1) != 0) begin
         send_char(CHAR_SEMI);
         bg_code = ($urandom_range(4) != 0) ? int'($urandom_range(40, 47))
                                            : int'($urandom_range(0, 299));
         send_decimal(bg_code);
         if ($urandom_range(7) == 0) begin
            send_char(CHAR_SEMI);
            send_decimal($urandom_range(0, 99));
         end
      end
      send_char(CHAR_SGR_END);
   endtask

   task automatic random_traffic(input int n);
      int stop_at;
      int pick;
      stop_at = chars_sent + n;
      while (chars_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            repeat ($urandom_range(1, 12)) begin
               if ($urandom_range(5) != 0) send_char(8'($urandom_range(8'h20, 8'h7e)));
               else send_char(8'($urandom_range(8'h80, 8'hff)));
            end
         end else if (pick < 58) begin
            case ($urandom_range(3))
               0: send_char(CHAR_BS);
               1: send_char(CHAR_TAB);
               2: send_char(CHAR_LF);
               default: send_char(CHAR_CR);
            endcase
         end else if (pick < 80) begin
            send_sgr();
         end else if (pick < 90) begin
            // broken escape: junk, digits and separators, maybe no introducer
            send_char(CHAR_ESC);
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(4))
                  0: send_char(CHAR_LBRACKET);
                  1: send_char(CHAR_SEMI);
                  2: send_char(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                  default: send_char(8'($urandom));
               endcase
            end
            if ($urandom_range(1) != 0) send_char(CHAR_SGR_END);
         end else begin
            send_char(8'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      send_char(CHAR_BS);
      send_char("A");
      send_char(8'h00);
      send_char(8'hff);
      send_char(CHAR_BS);
      send_char(CHAR_TAB);
      send_char(CHAR_CR);
      send_char(CHAR_LF);
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      send_char("3");
      send_char("1");
      send_char(CHAR_SEMI);
      send_char("4");
      send_char("2");
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char("3");
      send_char(CHAR_LBRACKET);
      send_char("3");
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char(CHAR_SGR_END);
      send_char("z");
      end_burst();
   endtask

   task automatic test_scroll_and_wrap();
      send_char("x");
      repeat (ROWS + 4) send_char(CHAR_LF);
      repeat (COLUMNS + 5) send_char(8'($urandom_range(8'h21, 8'h7e)));
      send_char(CHAR_BS);
      send_char(CHAR_BS);
      send_char(CHAR_CR);
      repeat (COLUMNS / 8 + 2) send_char(CHAR_TAB);
      send_char(CHAR_CR);
      send_char(CHAR_BS);
      end_burst();
   endtask

   task automatic test_escape_limits();
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      repeat (MAX_PARAMS + 2) send_char(CHAR_SEMI);
      send_decimal(31);
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      send_decimal(286);
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      send_decimal(31);
      send_char(CHAR_SEMI);
      send_decimal(42);
      send_char(CHAR_SEMI);
      send_decimal(1);
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      send_decimal(99);
      send_char(CHAR_SEMI);
      send_decimal(45);
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      send_char(CHAR_SEMI);
      send_decimal(41);
      send_char(CHAR_SGR_END);
      send_char(CHAR_ESC);
      send_char(CHAR_LBRACKET);
      send_decimal(37);
      send_char("q");
      send_char(CHAR_SGR_END);
      send_char("#");
      end_burst();
   endtask

   task automatic test_receiver_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         hold_receiver(300);
      join_none
      random_traffic(140);
      end_burst();
   endtask

   task automatic test_random_phase(input logic [31:0] map, input int send_pct,
                                    input int recv_pct, input int n);
      write_colour_map(map);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      random_traffic(n);
      end_burst();
   endtask

   // ------------------------------------------------------------------------
   // receiver, checker, watchdog
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      tte_result_type got;
      tte_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.cell_write, rsp_bus.cell_index, rsp_bus.cell_value,
                rsp_bus.scroll_up, rsp_bus.cursor_position, rsp_bus.attribute_now};
         if (expected_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("tb: unexpected word %h at cycle %0d", got, cycle_count);
         end else begin
            want = expected_cells.pop_front();
            cells_checked++;
            if (got.scroll_up) scrolls_seen++;
            if (got.cell_write != want.cell_write || got.cell_index != want.cell_index ||
                got.cell_value != want.cell_value || got.scroll_up != want.scroll_up ||
                got.cursor_position != want.cursor_position ||
                got.attribute_now != want.attribute_now) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("tb: word %0d exp wr=%b idx=%0d val=%h scr=%b cur=%0d attr=%h",
                           cells_checked, want.cell_write, want.cell_index, want.cell_value,
                           want.scroll_up, want.cursor_position, want.attribute_now,
                           "\n    got wr=%b idx=%0d val=%h scr=%b cur=%0d attr=%h",
                           got.cell_write, got.cell_index, got.cell_value,
                           got.scroll_up, got.cursor_position, got.attribute_now);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.char_code  = 8'd0;
      csr_bus.valid      = 1'b0;
      csr_bus.colour_map = 32'd0;
      map_model   = COLOUR_MAP_RESET;
      cur_row     = 5'd0;
      cur_col     = 7'd0;
      fg_now      = FG_RESET;
      bg_now      = BG_RESET;
      esc_active  = 1'b0;
      csi_active  = 1'b0;
      param_count = 4'd0;
      foreach (sgr_params[i]) sgr_params[i] = 8'd0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      write_colour_map(32'h0000_0000);
      test_scroll_and_wrap();
      write_colour_map(32'hffff_ffff);
      test_escape_limits();
      write_colour_map(32'h89ab_cdef);
      test_receiver_hold_off();
      test_random_phase(32'h7654_3210, 0, 0, 300);
      test_random_phase($urandom, 51, 0, 300);
      test_random_phase(COLOUR_MAP_RESET, 0, 51, 300);
      test_random_phase($urandom, 37, 37, 300);

      $display("tb: %0d bytes sent, %0d words checked, %0d scrolls, %0d mismatches",
               chars_sent, cells_checked, scrolls_seen, mismatch_count);
      $display("tb: covered edge cases, a long receiver hold-off and four idle mixes");
      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
